/* hw/rtl/mbrtu_pkg.sv */
// Shared types, codes and constants of the Modbus RTU slave frame engine.
package mbrtu_pkg;

	localparam int DEFAULT_NUM_REGS   = 16;
	localparam int FRAME_BYTES        = 8;
	localparam int REPLY_FIXED        = 5;
	localparam int RX_COUNT_W         = 8;

	localparam logic [7:0]  DEFAULT_SLAVE_ADDR = 8'd1;
	localparam logic [15:0] CRC_INIT           = 16'hFFFF;
	localparam logic [15:0] CRC_POLY           = 16'hA001;
	localparam logic [7:0]  EXC_FLAG           = 8'h80;
	localparam logic [7:0]  RX_COUNT_MAX       = 8'd255;

	// request codes
	localparam logic [1:0] REQ_BYTE    = 2'd0;
	localparam logic [1:0] REQ_SILENCE = 2'd1;
	localparam logic [1:0] REQ_WRITE   = 2'd2;
	localparam logic [1:0] REQ_READ    = 2'd3;

	// function codes
	localparam logic [7:0] FUNC_READ_HOLDING = 8'd3;
	localparam logic [7:0] FUNC_WRITE_SINGLE = 8'd6;
	localparam logic [7:0] FUNC_DIAG         = 8'd8;

	// exception codes
	localparam logic [7:0] EXC_ILLEGAL_FUNC = 8'd1;
	localparam logic [7:0] EXC_ILLEGAL_ADDR = 8'd2;
	localparam logic [7:0] EXC_ILLEGAL_DATA = 8'd3;

	// diagnostic selectors
	localparam logic [7:0] DIAG_LISTEN_ONLY = 8'd4;
	localparam logic [7:0] DIAG_BUS_COUNT   = 8'd11;
	localparam logic [7:0] DIAG_EXC_COUNT   = 8'd13;
	localparam logic [7:0] DIAG_SRV_COUNT   = 8'd14;

	// result kinds
	localparam logic RES_REPLY = 1'b0;
	localparam logic RES_LOCAL = 1'b1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_EVAL,
		S_BYTE,
		S_CRC,
		S_FETCH,
		S_LREAD
	} state_t;

	typedef enum logic [1:0] {
		RK_READ,
		RK_ECHO,
		RK_EXC,
		RK_DIAG
	} reply_kind_t;

	typedef struct packed {
		logic       init;
		logic       load;
		logic       shift;
		logic [7:0] data;
	} crc_ctl_t;

endpackage

/* hw/rtl/mbrtu_if.sv */
// Handshake interfaces of the request, result and configuration channels.
interface mbrtu_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  req_type;
	logic [7:0]  rx_byte;
	logic [3:0]  reg_index;
	logic [15:0] reg_value;
	modport source (output valid, req_type, rx_byte, reg_index, reg_value, input ready);
	modport sink   (input valid, req_type, rx_byte, reg_index, reg_value, output ready);
endinterface

interface mbrtu_rsp_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [7:0]  tx_byte;
	logic        last;
	logic [15:0] read_value;
	modport source (output valid, result_kind, tx_byte, last, read_value, input ready);
	modport sink   (input valid, result_kind, tx_byte, last, read_value, output ready);
endinterface

interface mbrtu_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;
	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

/* hw/rtl/mbrtu_crc.sv */
// Bit-serial CRC-16 unit, one polynomial step per cycle while shift is asserted.
module mbrtu_crc (
	input  logic                clk,
	input  logic                arst_n,
	input  mbrtu_pkg::crc_ctl_t ctl,
	output logic [15:0]         crc
);
	import mbrtu_pkg::*;

	logic [15:0] crc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q <= CRC_INIT;
		end else if (ctl.init) begin
			crc_q <= CRC_INIT;
		end else if (ctl.load) begin
			crc_q <= crc_q ^ {8'd0, ctl.data};
		end else if (ctl.shift) begin
			crc_q <= crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
		end
	end

	assign crc = crc_q;
endmodule

/* hw/rtl/mbrtu_regs.sv */
// Holding register memory with per-entry valid bits and a registered read port.
module mbrtu_regs #(
	parameter int NUM_REGS = mbrtu_pkg::DEFAULT_NUM_REGS,
	parameter int RW       = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          we,
	input  logic [RW-1:0] waddr,
	input  logic [15:0]   wdata,
	input  logic          re,
	input  logic [RW-1:0] raddr,
	output logic [15:0]   rdata
);
	import mbrtu_pkg::*;

	logic [15:0]         mem [NUM_REGS];
	logic [NUM_REGS-1:0] vld_q;
	logic [15:0]         rd_q;
	logic                rvld_q;
	logic                rin;

	assign rin = 32'(raddr) < NUM_REGS;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re && rin) begin
			rd_q <= mem[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q  <= '0;
			rvld_q <= 1'b0;
		end else begin
			if (we) begin
				vld_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvld_q <= rin && vld_q[raddr];
			end
		end
	end

	// entries never written read as zero
	assign rdata = rvld_q ? rd_q : 16'd0;
endmodule

/* hw/rtl/modbus_rtu_slave_frame_engine_top.sv */
// Top level of the Modbus RTU slave frame engine: frame capture, service and reply sequencer.
//
//  channel | dir | handshake   | payload
//  --------+-----+-------------+------------------------------------------
//  req     | in  | valid/ready | req_type, rx_byte, reg_index, reg_value
//  rsp     | out | valid/ready | result_kind, tx_byte, last, read_value
//  cfg     | in  | valid/ready | data (slave address, always ready)
//
//  A received byte or a local write is taken in idle; a local read goes through S_LREAD and
//  waits for the output register. A frame end is decided in S_EVAL, then each reply byte is
//  loaded in S_BYTE, data bytes also run the bit-serial CRC steps in S_CRC, and each register
//  adds one S_FETCH state. The reply rate is set by the single CRC shift unit.
//  Reset clears counters, buffer, listen-only, valid bits of the holding registers; address is 1.
//  The output register stalls the sequencer only when a byte waits for rsp.ready.
module modbus_rtu_slave_frame_engine_top #(
	parameter int NUM_REGS = mbrtu_pkg::DEFAULT_NUM_REGS
) (
	input  logic         clk,
	input  logic         arst_n,
	mbrtu_req_if.sink    req,
	mbrtu_rsp_if.source  rsp,
	mbrtu_cfg_if.sink    cfg
);
	import mbrtu_pkg::*;

	localparam int RW     = (NUM_REGS > 1) ? $clog2(NUM_REGS) : 1;
	localparam int MAXLEN = REPLY_FIXED + 2 * NUM_REGS;
	localparam int LW     = $clog2(MAXLEN + 1);

	state_t state_q, state_d;

	logic [7:0]  slave_addr_q;
	logic [7:0]  rxb_q [FRAME_BYTES];
	logic [RX_COUNT_W-1:0] rx_count_q;
	logic [15:0] bus_cnt_q, srv_cnt_q, exc_cnt_q;
	logic        listen_q;

	// reply context
	reply_kind_t kind_q;
	logic [7:0]  b1_q, b2_q, b3_q, b4_q, b5_q;
	logic [LW-1:0] pos_q, crc_pos_q, last_pos_q;
	logic [RW-1:0] ptr_q;
	logic [2:0]  bit_q;
	logic        lr_ok_q;

	// result register
	logic        rsp_valid_q;
	logic        rsp_kind_q;
	logic [7:0]  rsp_byte_q;
	logic        rsp_last_q;
	logic [15:0] rsp_value_q;

	logic        req_fire, rsp_free;
	logic [15:0] fa, fb;
	logic [7:0]  fcode;
	logic        a_ok, idx_ok;
	logic [15:0] crc;
	logic [15:0] rd_word;
	crc_ctl_t    crc_ctl;

	// evaluation results
	logic        ev_reply, ev_exc, ev_write, ev_listen;
	reply_kind_t ev_kind;
	logic [7:0]  ev_b1, ev_b2, ev_b3, ev_b4, ev_b5;
	logic [LW-1:0] ev_len;

	// sequencer outputs
	logic [7:0]  cur_byte;
	logic        is_data, is_last, byte_load, crc_done, fetch_next;
	logic [LW-1:0] pos_inc;
	logic        mem_we, mem_re;
	logic [RW-1:0] mem_waddr, mem_raddr;
	logic [15:0] mem_wdata;

	assign req_fire  = req.valid && req.ready;
	assign req.ready = (state_q == S_IDLE);
	assign cfg.ready = 1'b1;
	assign rsp_free  = !rsp_valid_q || rsp.ready;

	assign fcode  = rxb_q[1];
	assign fa     = {rxb_q[2], rxb_q[3]};
	assign fb     = {rxb_q[4], rxb_q[5]};
	assign a_ok   = fa < 16'(NUM_REGS);
	assign idx_ok = 32'(req.reg_index) < NUM_REGS;

	mbrtu_crc u_crc (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (crc_ctl),
		.crc    (crc)
	);

	mbrtu_regs #(
		.NUM_REGS (NUM_REGS),
		.RW       (RW)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (mem_we),
		.waddr  (mem_waddr),
		.wdata  (mem_wdata),
		.re     (mem_re),
		.raddr  (mem_raddr),
		.rdata  (rd_word)
	);

	// Decide the reply from the captured frame.
	always_comb begin
		ev_reply  = 1'b1;
		ev_exc    = 1'b0;
		ev_write  = 1'b0;
		ev_listen = 1'b0;
		ev_kind   = RK_EXC;
		ev_b1     = fcode | EXC_FLAG;
		ev_b2     = EXC_ILLEGAL_FUNC;
		ev_b3     = rxb_q[3];
		ev_b4     = rxb_q[4];
		ev_b5     = rxb_q[5];
		ev_len    = LW'(REPLY_FIXED);
		case (fcode)
			FUNC_READ_HOLDING: begin
				if (!a_ok) begin
					ev_exc = 1'b1;
					ev_b2  = EXC_ILLEGAL_ADDR;
				end else if (({1'b0, fa} + {1'b0, fb}) > 17'(NUM_REGS)) begin
					ev_exc = 1'b1;
					ev_b2  = EXC_ILLEGAL_DATA;
				end else begin
					ev_kind = RK_READ;
					ev_b1   = fcode;
					ev_b2   = {fb[6:0], 1'b0};
					ev_len  = LW'(17'(REPLY_FIXED) + {fb, 1'b0});
				end
			end
			FUNC_WRITE_SINGLE: begin
				if (!a_ok) begin
					ev_exc = 1'b1;
					ev_b2  = EXC_ILLEGAL_ADDR;
				end else begin
					ev_write = 1'b1;
					ev_kind  = RK_ECHO;
					ev_b1    = fcode;
					ev_b2    = rxb_q[2];
					ev_len   = LW'(FRAME_BYTES);
				end
			end
			FUNC_DIAG: begin
				ev_kind = RK_DIAG;
				ev_b1   = fcode;
				ev_b2   = rxb_q[2];
				ev_len  = LW'(7);
				case (rxb_q[2])
					DIAG_LISTEN_ONLY: begin
						ev_listen = 1'b1;
						ev_reply  = 1'b0;
					end
					DIAG_BUS_COUNT: begin
						ev_b3 = bus_cnt_q[7:0];
						ev_b4 = bus_cnt_q[15:8];
					end
					DIAG_EXC_COUNT: begin
						ev_b3 = exc_cnt_q[7:0];
						ev_b4 = exc_cnt_q[15:8];
					end
					DIAG_SRV_COUNT: begin
						ev_b3 = srv_cnt_q[7:0];
						ev_b4 = srv_cnt_q[15:8];
					end
					default: ev_reply = 1'b0;
				endcase
			end
			default: ev_exc = 1'b1;
		endcase
	end

	// Select the reply byte at the current position.
	always_comb begin
		is_data = pos_q < crc_pos_q;
		is_last = pos_q == last_pos_q;
		case (pos_q)
			LW'(0):  cur_byte = slave_addr_q;
			LW'(1):  cur_byte = b1_q;
			LW'(2):  cur_byte = b2_q;
			LW'(3):  cur_byte = b3_q;
			LW'(4):  cur_byte = b4_q;
			LW'(5):  cur_byte = b5_q;
			default: cur_byte = rxb_q[5];
		endcase
		if (kind_q == RK_READ && pos_q >= LW'(3)) begin
			cur_byte = pos_q[0] ? rd_word[15:8] : rd_word[7:0];
		end
		if (!is_data) begin
			cur_byte = is_last ? crc[15:8] : crc[7:0];
		end
	end

	assign pos_inc    = pos_q + LW'(1);
	// hold the next register word ready before its high byte
	assign fetch_next = (kind_q == RK_READ) && pos_inc[0] && (pos_inc >= LW'(3))
		&& (pos_inc < crc_pos_q);
	assign crc_done   = (bit_q == 3'd7);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (req_fire) begin
					case (req.req_type)
						REQ_SILENCE: if (rxb_q[0] == slave_addr_q) state_d = S_EVAL;
						REQ_READ:    state_d = S_LREAD;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_EVAL: state_d = (ev_reply && !listen_q) ? S_BYTE : S_IDLE;
			S_BYTE: begin
				if (rsp_free) begin
					if (is_data)      state_d = S_CRC;
					else if (is_last) state_d = S_IDLE;
				end
			end
			S_CRC:   if (crc_done) state_d = fetch_next ? S_FETCH : S_BYTE;
			S_FETCH: state_d = S_BYTE;
			S_LREAD: if (rsp_free) state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		crc_ctl   = '0;
		byte_load = 1'b0;
		mem_we    = 1'b0;
		mem_waddr = RW'(req.reg_index);
		mem_wdata = req.reg_value;
		mem_re    = 1'b0;
		mem_raddr = RW'(req.reg_index);
		crc_ctl.data = cur_byte;
		case (state_q)
			S_IDLE: begin
				mem_we = req_fire && (req.req_type == REQ_WRITE) && idx_ok;
				mem_re = req_fire && (req.req_type == REQ_READ);
			end
			S_EVAL: begin
				mem_we       = ev_write;
				mem_waddr    = RW'(fa);
				mem_wdata    = fb;
				crc_ctl.init = 1'b1;
			end
			S_BYTE: begin
				byte_load    = rsp_free;
				crc_ctl.load = rsp_free && is_data;
			end
			S_CRC:   crc_ctl.shift = 1'b1;
			S_FETCH: begin
				mem_re    = 1'b1;
				mem_raddr = ptr_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			slave_addr_q <= DEFAULT_SLAVE_ADDR;
			rx_count_q   <= '0;
			for (int i = 0; i < FRAME_BYTES; i++) rxb_q[i] <= 8'd0;
			bus_cnt_q    <= '0;
			srv_cnt_q    <= '0;
			exc_cnt_q    <= '0;
			listen_q     <= 1'b0;
			rsp_valid_q  <= 1'b0;
			pos_q        <= '0;
			bit_q        <= '0;
		end else begin
			state_q <= state_d;
			if (cfg.valid) begin
				slave_addr_q <= cfg.data;
			end
			if (req_fire) begin
				case (req.req_type)
					REQ_BYTE: begin
						// store up to a frame's worth, saturate the count
						if (rx_count_q < RX_COUNT_W'(FRAME_BYTES)) begin
							rxb_q[rx_count_q[2:0]] <= req.rx_byte;
						end
						if (rx_count_q != RX_COUNT_MAX) rx_count_q <= rx_count_q + 1'b1;
					end
					REQ_SILENCE: begin
						rx_count_q <= '0;
						if (rxb_q[0] == slave_addr_q) begin
							srv_cnt_q <= srv_cnt_q + 1'b1;
						end else begin
							bus_cnt_q <= bus_cnt_q + 1'b1;
						end
					end
					default: ;
				endcase
			end
			if (state_q == S_EVAL) begin
				// bus count of an own frame advances when it is evaluated; a diagnostic reply shows the old count
				bus_cnt_q <= bus_cnt_q + 1'b1;
				if (ev_exc)    exc_cnt_q <= exc_cnt_q + 1'b1;
				if (ev_listen) listen_q  <= 1'b1;
				pos_q <= '0;
			end
			if (state_q == S_BYTE && rsp_free && !is_data && !is_last) begin
				pos_q <= pos_inc;
			end
			if (state_q == S_BYTE && rsp_free && is_data) begin
				bit_q <= '0;
			end
			if (state_q == S_CRC) begin
				bit_q <= bit_q + 1'b1;
				if (crc_done) pos_q <= pos_inc;
			end
			if (byte_load || (state_q == S_LREAD && rsp_free)) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (req_fire && req.req_type == REQ_READ) begin
			lr_ok_q <= idx_ok;
		end
		if (state_q == S_EVAL) begin
			kind_q     <= ev_kind;
			b1_q       <= ev_b1;
			b2_q       <= ev_b2;
			b3_q       <= ev_b3;
			b4_q       <= ev_b4;
			b5_q       <= ev_b5;
			crc_pos_q  <= ev_len - LW'(2);
			last_pos_q <= ev_len - LW'(1);
			ptr_q      <= RW'(fa);
		end
		if (state_q == S_FETCH) begin
			ptr_q <= ptr_q + 1'b1;
		end
		if (byte_load) begin
			rsp_kind_q  <= RES_REPLY;
			rsp_byte_q  <= cur_byte;
			rsp_last_q  <= is_last;
			rsp_value_q <= 16'd0;
		end else if (state_q == S_LREAD && rsp_free) begin
			rsp_kind_q  <= RES_LOCAL;
			rsp_byte_q  <= 8'd0;
			rsp_last_q  <= 1'b0;
			rsp_value_q <= lr_ok_q ? rd_word : 16'd0;
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.result_kind = rsp_kind_q;
	assign rsp.tx_byte     = rsp_byte_q;
	assign rsp.last        = rsp_last_q;
	assign rsp.read_value  = rsp_value_q;
endmodule

/* hw/rtl/mbrtu_checker.sv */
// Port-level checker of the frame engine and its bind to the top level.
module mbrtu_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic [1:0]  req_type,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        rsp_kind,
	input logic [7:0]  rsp_byte,
	input logic        rsp_last,
	input logic [15:0] rsp_value
);
	import mbrtu_pkg::*;

	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_byte) && $stable(rsp_value)
			&& $stable(rsp_last) && $stable(rsp_kind))
		else $error("stalled result changed");

	a_lread_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && req_type == REQ_READ |=> !req_ready)
		else $error("ready during local read");

	a_byte_quick: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready && (req_type == REQ_BYTE || req_type == REQ_WRITE)
			|=> req_ready)
		else $error("byte or write did not finish in one cycle");

	a_local_fmt: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_kind |-> rsp_byte == 8'd0 && !rsp_last)
		else $error("local read result carries reply fields");
endmodule

bind modbus_rtu_slave_frame_engine_top mbrtu_checker u_mbrtu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.req_type  (req.req_type),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_kind  (rsp.result_kind),
	.rsp_byte  (rsp.tx_byte),
	.rsp_last  (rsp.last),
	.rsp_value (rsp.read_value)
);

/* sim/mbrtu_tb_checker.sv */
// Watches the request, result and configuration channels of the frame engine and checks replies and local reads.
module mbrtu_tb_checker #(
	parameter int NUM_REGS = mbrtu_pkg::DEFAULT_NUM_REGS
) (
	input  logic       clk,
	input  logic       arst_n,
	mbrtu_req_if.sink  req,
	mbrtu_rsp_if.sink  rsp,
	mbrtu_cfg_if.sink  cfg,
	output int         fail_count,
	output int         pending_count,
	output logic       accepted
);
	timeunit 1ns;
	timeprecision 1ps;
	import mbrtu_pkg::*;

	typedef struct packed {
		logic        kind;
		logic [7:0]  tx;
		logic        last;
		logic [15:0] rd;
	} result_t;

	result_t     expected_q[$];
	logic [7:0]  own_addr;
	logic [7:0]  frame_buf [FRAME_BYTES];
	logic [7:0]  byte_cnt;
	logic [15:0] regs [NUM_REGS];
	logic [15:0] bus_cnt, srv_cnt, exc_cnt;
	logic        silent;

	assign pending_count = expected_q.size();
	assign accepted = (req.valid && req.ready) || (rsp.valid && rsp.ready) ||
		(cfg.valid && cfg.ready);

	function automatic logic [15:0] crc_of(input logic [7:0] b [], input int n);
		logic [15:0] c;
		c = CRC_INIT;
		for (int i = 0; i < n; i++) begin
			c ^= {8'h00, b[i]};
			for (int k = 0; k < 8; k++)
				c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
		end
		return c;
	endfunction

	// Append a reply frame with its CRC, unless the station is silenced.
	task automatic queue_reply(input logic [7:0] b [], input int n);
		logic [15:0] c;
		result_t r;
		if (silent) return;
		b[0] = own_addr;
		c = crc_of(b, n - 2);
		b[n - 2] = c[7:0];
		b[n - 1] = c[15:8];
		for (int i = 0; i < n; i++) begin
			r = '{RES_REPLY, b[i], i == n - 1, 16'h0};
			expected_q.push_back(r);
		end
	endtask

	task automatic queue_exception(input logic [7:0] fn, input logic [7:0] code);
		logic [7:0] b [];
		b = new[5];
		exc_cnt++;
		b[1] = fn | EXC_FLAG;
		b[2] = code;
		queue_reply(b, 5);
	endtask

	task automatic serve_frame();
		logic [7:0] b [];
		logic [7:0] fn;
		int unsigned a, cnt;
		logic [15:0] v;
		fn = frame_buf[1];
		a = {frame_buf[2], frame_buf[3]};
		cnt = {frame_buf[4], frame_buf[5]};
		case (fn)
			FUNC_READ_HOLDING: begin
				if (a >= NUM_REGS) queue_exception(fn, EXC_ILLEGAL_ADDR);
				else if (a + cnt > NUM_REGS) queue_exception(fn, EXC_ILLEGAL_DATA);
				else begin
					b = new[5 + 2 * cnt];
					b[1] = fn;
					b[2] = 8'(cnt * 2);
					for (int i = 0; i < cnt; i++) begin
						b[3 + 2 * i] = regs[a + i][15:8];
						b[4 + 2 * i] = regs[a + i][7:0];
					end
					queue_reply(b, 5 + 2 * cnt);
				end
			end
			FUNC_WRITE_SINGLE: begin
				if (a >= NUM_REGS) queue_exception(fn, EXC_ILLEGAL_ADDR);
				else begin
					regs[a] = 16'(cnt);
					b = new[FRAME_BYTES];
					for (int i = 0; i < FRAME_BYTES; i++) b[i] = frame_buf[i];
					queue_reply(b, FRAME_BYTES);
				end
			end
			FUNC_DIAG: begin
				v = 16'h0;
				case (frame_buf[2])
					DIAG_LISTEN_ONLY: silent = 1'b1;
					DIAG_BUS_COUNT:   v = bus_cnt;
					DIAG_EXC_COUNT:   v = exc_cnt;
					DIAG_SRV_COUNT:   v = srv_cnt;
					default: ;
				endcase
				if (frame_buf[2] inside {DIAG_BUS_COUNT, DIAG_EXC_COUNT, DIAG_SRV_COUNT}) begin
					b = new[7];
					b[1] = fn;
					b[2] = frame_buf[2];
					b[3] = v[7:0];
					b[4] = v[15:8];
					queue_reply(b, 7);
				end
			end
			default: queue_exception(fn, EXC_ILLEGAL_FUNC);
		endcase
	endtask

	always @(posedge clk or negedge arst_n) begin
		result_t got, want;
		if (!arst_n) begin
			expected_q.delete();
			own_addr = DEFAULT_SLAVE_ADDR;
			foreach (frame_buf[i]) frame_buf[i] = 8'h0;
			foreach (regs[i]) regs[i] = 16'h0;
			byte_cnt = 8'h0;
			bus_cnt = 16'h0;
			srv_cnt = 16'h0;
			exc_cnt = 16'h0;
			silent = 1'b0;
			fail_count <= 0;
		end else begin
			if (cfg.valid && cfg.ready) own_addr = cfg.data;
			if (req.valid && req.ready) begin
				case (req.req_type)
					REQ_BYTE: begin
						if (byte_cnt < RX_COUNT_MAX) byte_cnt++;
						if (byte_cnt <= FRAME_BYTES) frame_buf[byte_cnt - 1] = req.rx_byte;
					end
					REQ_SILENCE: begin
						if (frame_buf[0] == own_addr) begin
							srv_cnt++;
							serve_frame();
						end
						bus_cnt++;
						byte_cnt = 8'h0;
					end
					REQ_WRITE: if (req.reg_index < NUM_REGS) regs[req.reg_index] = req.reg_value;
					default: begin
						want = '{RES_LOCAL, 8'h0, 1'b0,
							(req.reg_index < NUM_REGS) ? regs[req.reg_index] : 16'h0};
						expected_q.push_back(want);
					end
				endcase
			end
			if (rsp.valid && rsp.ready) begin
				got = '{rsp.result_kind, rsp.tx_byte, rsp.last, rsp.read_value};
				if (expected_q.size() == 0) begin
					if (fail_count < 10) $display("checker: unexpected result %h", got);
					fail_count <= fail_count + 1;
				end else begin
					want = expected_q.pop_front();
					if (got !== want) begin
						if (fail_count < 10)
							$display("checker: mismatch kind %0b/%0b byte %h/%h last %0b/%0b rd %h/%h",
								want.kind, got.kind, want.tx, got.tx, want.last, got.last,
								want.rd, got.rd);
						fail_count <= fail_count + 1;
					end
				end
			end
		end
	end
endmodule

/* sim/testbench.sv */
// Stimulus and verdict for the Modbus RTU slave frame engine.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import mbrtu_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 400;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	int   fail_count, pending_count, idle_cycles;
	logic accepted;
	int   send_idle_pct, recv_idle_pct;

	mbrtu_req_if req ();
	mbrtu_rsp_if rsp ();
	mbrtu_cfg_if cfg ();

	always #5 clk = ~clk;

	modbus_rtu_slave_frame_engine_top u_top (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.source), .cfg(cfg.sink)
	);

	mbrtu_tb_checker u_checker (
		.clk(clk), .arst_n(arst_n), .req(req.sink), .rsp(rsp.sink), .cfg(cfg.sink),
		.fail_count(fail_count), .pending_count(pending_count), .accepted(accepted)
	);

	// Toggle the receiver's ready at the falling edge, idling at the current rate.
	always @(negedge clk) begin
		rsp.ready <= ($urandom_range(99) >= recv_idle_pct);
	end

	// Count cycles with no transaction on any channel; end the run on a hang.
	always @(posedge clk) begin
		if (!arst_n || accepted) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("testbench: done, errors");
			$finish;
		end
	end

	// Send one request and hold it until the block takes it; drop valid only while idling.
	task automatic send_req(input logic [1:0] kind, input logic [7:0] b,
			input logic [3:0] idx, input logic [15:0] val);
		while ($urandom_range(99) < send_idle_pct) begin
			req.valid <= 1'b0;
			@(negedge clk);
		end
		req.valid     <= 1'b1;
		req.req_type  <= kind;
		req.rx_byte   <= b;
		req.reg_index <= idx;
		req.reg_value <= val;
		@(posedge clk);
		while (!req.ready) @(posedge clk);
		@(negedge clk);
	endtask

	// Deliver a whole frame of bytes, then the silence that ends it.
	task automatic send_frame(input logic [7:0] f [], input int n);
		for (int i = 0; i < n; i++) send_req(REQ_BYTE, f[i], 4'($urandom), 16'($urandom));
		send_req(REQ_SILENCE, 8'($urandom), 4'($urandom), 16'($urandom));
	endtask

	// Send the six bytes that carry address, function and both fields; the rest is unused.
	task automatic frame6(input logic [7:0] a, input logic [7:0] fn, input logic [15:0] x,
			input logic [15:0] y);
		logic [7:0] f [];
		f = new[6];
		f = '{a, fn, x[15:8], x[7:0], y[15:8], y[7:0]};
		send_frame(f, 6);
	endtask

	// Wait for every expected result, then let the block settle before a register write.
	task automatic drain_and_settle();
		req.valid <= 1'b0;
		while (pending_count != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_addr(input logic [7:0] a);
		cfg.valid <= 1'b1;
		cfg.data  <= a;
		@(posedge clk);
		while (!cfg.ready) @(posedge clk);
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	// Local accesses and mostly well-formed frames to the own address with random content, some noise.
	task automatic random_items(input int n, input logic [7:0] own);
		logic [7:0] f [];
		int len;
		for (int i = 0; i < n; i++) begin
			case ($urandom_range(9))
				0: send_req(REQ_WRITE, 8'($urandom), 4'($urandom), 16'($urandom));
				1: send_req(REQ_READ, 8'($urandom), 4'($urandom), 16'($urandom));
				2: begin
					len = $urandom_range(12);
					f = new[len];
					foreach (f[k]) f[k] = 8'($urandom);
					if (len > 0 && $urandom_range(1)) f[0] = own;
					send_frame(f, len);
				end
				3, 4: frame6(own, FUNC_READ_HOLDING, 16'($urandom_range(17)),
					16'($urandom_range(17)));
				5, 6: frame6(own, FUNC_WRITE_SINGLE, $urandom_range(3) == 0 ?
					16'($urandom) : 16'($urandom_range(15)), 16'($urandom));
				7: frame6(own, FUNC_DIAG, {8'($urandom_range(3) == 0 ? $urandom :
					($urandom_range(1) ? 11 : $urandom_range(13, 14))), 8'($urandom)},
					16'($urandom));
				8: frame6(own, 8'($urandom), 16'($urandom), 16'($urandom));
				default: frame6(8'($urandom), 8'($urandom), 16'($urandom), 16'($urandom));
			endcase
		end
	endtask

	initial begin
		logic [7:0] f [];
		req.valid = 1'b0; req.req_type = REQ_BYTE; req.rx_byte = 8'h0;
		req.reg_index = 4'h0; req.reg_value = 16'h0;
		cfg.valid = 1'b0; cfg.data = 8'h0;
		send_idle_pct = 20;
		recv_idle_pct = 65;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// Directed: local access at the extremes, every function, each range case.
		send_req(REQ_WRITE, 8'h00, 4'hF, 16'hFFFF);
		send_req(REQ_WRITE, 8'hFF, 4'h0, 16'h0000);
		send_req(REQ_READ, 8'h00, 4'hF, 16'h0);
		send_req(REQ_READ, 8'hFF, 4'h0, 16'hFFFF);
		frame6(8'h01, FUNC_READ_HOLDING, 16'd0, 16'd16);
		frame6(8'h01, FUNC_READ_HOLDING, 16'd16, 16'd1);
		frame6(8'h01, FUNC_READ_HOLDING, 16'd15, 16'hFFFF);
		frame6(8'h01, FUNC_READ_HOLDING, 16'd3, 16'd0);
		frame6(8'h01, FUNC_WRITE_SINGLE, 16'd7, 16'hA5C3);
		frame6(8'h01, FUNC_WRITE_SINGLE, 16'hFFFF, 16'h1234);
		frame6(8'h01, 8'hFF, 16'h0, 16'h0);
		frame6(8'h01, FUNC_DIAG, {DIAG_BUS_COUNT, 8'h00}, 16'h0);
		frame6(8'h01, FUNC_DIAG, {DIAG_EXC_COUNT, 8'h00}, 16'h0);
		frame6(8'h01, FUNC_DIAG, {DIAG_SRV_COUNT, 8'h00}, 16'h0);
		frame6(8'h01, FUNC_DIAG, {8'h00, 8'h00}, 16'h0);
		frame6(8'h02, FUNC_READ_HOLDING, 16'd0, 16'd1);
		// Long frame: bytes past the eighth are dropped.
		f = new[9];
		foreach (f[k]) f[k] = (k == 0) ? 8'h01 : ((k == 1) ? FUNC_READ_HOLDING : 8'(k));
		f[2] = 8'h00; f[3] = 8'h02; f[4] = 8'h00; f[5] = 8'h02;
		send_frame(f, 9);
		// Short and empty frames reuse stale buffer bytes.
		f = new[1];
		f[0] = 8'h01;
		send_frame(f, 1);
		send_frame(f, 0);

		drain_and_settle();
		write_addr(8'hFF);
		send_idle_pct = 65;
		recv_idle_pct = 20;
		random_items(2, 8'hFF);
		drain_and_settle();
		write_addr(8'h00);
		send_idle_pct = 0;
		recv_idle_pct = 0;
		random_items(2, 8'h00);
		// Listen-only last: replies stop, local reads still return.
		frame6(8'h00, FUNC_DIAG, {DIAG_LISTEN_ONLY, 8'h00}, 16'h0);
		frame6(8'h00, FUNC_WRITE_SINGLE, 16'd2, 16'h5A5A);
		send_req(REQ_READ, 8'h00, 4'd2, 16'h0);

		drain_and_settle();
		if (fail_count == 0) $display("testbench: done, clean");
		else $display("testbench: done, errors");
		$finish;
	end
endmodule

/* files.f */
hw/rtl/mbrtu_pkg.sv
hw/rtl/mbrtu_if.sv
hw/rtl/mbrtu_crc.sv
hw/rtl/mbrtu_regs.sv
hw/rtl/modbus_rtu_slave_frame_engine_top.sv
hw/rtl/mbrtu_checker.sv
sim/mbrtu_tb_checker.sv
sim/testbench.sv
